FILE: src/dpt_pkg.sv
package dpt_pkg;

    typedef enum logic [1:0] {
        CMD_ADVERT = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_REPORT = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_RSSI_FLOOR   = 2'd0;
    localparam logic [1:0] REG_START_TTL    = 2'd1;
    localparam logic [1:0] REG_FRESH_MARGIN = 2'd2;

    localparam logic [7:0] RSSI_FLOOR_RESET   = 8'hA6;
    localparam logic [7:0] START_TTL_RESET    = 8'd10;
    localparam logic [7:0] FRESH_MARGIN_RESET = 8'd1;

    // stored entry, valid bits kept apart in flip-flops
    typedef struct packed {
        logic [47:0] address;
        logic [7:0]  rssi;
        logic [7:0]  ttl;
        logic [1:0]  address_type;
        logic [15:0] appearance;
    } entry_t;

endpackage

FILE: src/device_presence_table_top_rssi.sv
// channel   dir  fields
// s_axis    in   cmd, mac_address, rssi, address_type, appearance
// m_axis    out  out_address, out_rssi, out_address_type, out_appearance,
//                last_of_report, report_empty
// apb       in   rssi_floor, start_ttl, fresh_margin
// advertisement: one memory read per slot to find hit and free slot
// tick: one read per slot, a read-modify-write for each valid slot
// report: one scan per reported word plus a final scan
// that finds none (left out once MAX_REPORT words are found)
// reset clears the valid bits at once; the entry memory needs no clearing
// m_axis stalls hold the report scan; s_axis is ready only between items
module device_presence_table_top_rssi
    import dpt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int MAX_REPORT  = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0], mac_address[49:2], rssi[57:50], address_type[59:58],
    // appearance[75:60], zero fill to 80
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_address[47:0], out_rssi[55:48], out_address_type[57:56],
    // out_appearance[73:58], zero fill to 80
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // report_empty
    output logic        m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int RW = $clog2(MAX_REPORT + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_ADV_WR,
        ST_TICK,
        ST_RPT,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic [7:0]  rssi_floor_reg, start_ttl_reg, fresh_margin_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] taken_reg;
    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          rd_pend_reg;
    logic [CW-1:0] scan_reg;
    logic [47:0] in_addr_reg;
    logic [7:0]  in_rssi_reg;
    logic [1:0]  in_type_reg;
    logic [15:0] in_app_reg;
    logic        hit_found_reg, free_found_reg, best_found_reg;
    logic [AW-1:0] hit_reg, free_reg, best_reg;
    entry_t      best_e_reg;
    // found entry waiting until it is known whether another follows
    entry_t      hold_e_reg;
    logic [RW-1:0] count_reg;
    logic        out_valid_reg, out_last_reg, out_empty_reg;
    entry_t      out_e_reg;

    logic wr_en;
    logic [AW-1:0] wr_addr;
    entry_t wr_data;
    logic [AW-1:0] rd_addr;
    logic signed [9:0] threshold;
    logic fresh;
    logic emit;

    assign pready = 1'b1;
    assign threshold = $signed({2'b00, start_ttl_reg}) - $signed({2'b00, fresh_margin_reg});
    assign fresh = $signed({2'b00, rd_data_reg.ttl}) >= threshold;
    assign emit = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready) &&
                  (!best_found_reg || count_reg != '0);

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RSSI_FLOOR:   prdata = {{24{rssi_floor_reg[7]}}, rssi_floor_reg};
            REG_START_TTL:    prdata = {24'd0, start_ttl_reg};
            REG_FRESH_MARGIN: prdata = {24'd0, fresh_margin_reg};
            default:          prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_e_reg.appearance, out_e_reg.address_type,
                            out_e_reg.rssi, out_e_reg.address};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_empty_reg;

    assign rd_addr = scan_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = rd_addr_reg;
        wr_data = rd_data_reg;
        if (state_reg == ST_ADV_WR && (hit_found_reg || free_found_reg))
        begin
            wr_en = 1'b1;
            wr_addr = hit_found_reg ? hit_reg : free_reg;
            wr_data.address = in_addr_reg;
            wr_data.rssi = in_rssi_reg;
            wr_data.ttl = start_ttl_reg;
            wr_data.address_type = in_type_reg;
            wr_data.appearance = in_app_reg;
        end
        else if (state_reg == ST_TICK && rd_pend_reg && valid_reg[rd_addr_reg])
        begin
            wr_en = 1'b1;
            wr_data.ttl = rd_data_reg.ttl - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rssi_floor_reg <= RSSI_FLOOR_RESET;
            start_ttl_reg <= START_TTL_RESET;
            fresh_margin_reg <= FRESH_MARGIN_RESET;
            valid_reg <= '0;
            taken_reg <= '0;
            rd_pend_reg <= 1'b0;
            scan_reg <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg <= 1'b0;
            out_empty_reg <= 1'b0;
            hit_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                unique case (paddr[3:2])
                    REG_RSSI_FLOOR:   rssi_floor_reg <= pwdata[7:0];
                    REG_START_TTL:    start_ttl_reg <= pwdata[7:0];
                    REG_FRESH_MARGIN: fresh_margin_reg <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_addr_reg <= rd_addr;
            unique case (state_reg)
                ST_IDLE:
                begin
                    scan_reg <= '0;
                    rd_pend_reg <= 1'b0;
                    hit_found_reg <= 1'b0;
                    free_found_reg <= 1'b0;
                    best_found_reg <= 1'b0;
                    taken_reg <= '0;
                    count_reg <= '0;
                    in_addr_reg <= s_axis_tdata[49:2];
                    in_rssi_reg <= s_axis_tdata[57:50];
                    in_type_reg <= s_axis_tdata[59:58];
                    in_app_reg <= s_axis_tdata[75:60];
                    if (s_axis_tvalid)
                    begin
                        unique case (cmd_t'(s_axis_tdata[1:0]))
                            CMD_ADVERT:
                                if ($signed(s_axis_tdata[57:50]) >= $signed(rssi_floor_reg))
                                    state_reg <= ST_ADV;
                            CMD_TICK:   state_reg <= ST_TICK;
                            CMD_REPORT: state_reg <= ST_RPT;
                            CMD_NONE:   ;
                        endcase
                    end
                end
                ST_ADV, ST_TICK, ST_RPT:
                begin
                    if (scan_reg != CW'(TABLE_DEPTH))
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    rd_pend_reg <= (scan_reg != CW'(TABLE_DEPTH));
                    if (rd_pend_reg)
                    begin
                        if (state_reg == ST_ADV)
                        begin
                            if (valid_reg[rd_addr_reg])
                            begin
                                if (!hit_found_reg && rd_data_reg.address == in_addr_reg)
                                begin
                                    hit_found_reg <= 1'b1;
                                    hit_reg <= rd_addr_reg;
                                end
                            end
                            else if (!free_found_reg)
                            begin
                                free_found_reg <= 1'b1;
                                free_reg <= rd_addr_reg;
                            end
                        end
                        else if (state_reg == ST_TICK)
                        begin
                            if (valid_reg[rd_addr_reg] && rd_data_reg.ttl <= 8'd1)
                                valid_reg[rd_addr_reg] <= 1'b0;
                        end
                        else if (valid_reg[rd_addr_reg] && !taken_reg[rd_addr_reg] && fresh &&
                                 (!best_found_reg ||
                                  $signed(rd_data_reg.rssi) > $signed(best_e_reg.rssi)))
                        begin
                            best_found_reg <= 1'b1;
                            best_reg <= rd_addr_reg;
                            best_e_reg <= rd_data_reg;
                        end
                    end
                    if (scan_reg == CW'(TABLE_DEPTH) && !rd_pend_reg)
                    begin
                        unique case (state_reg)
                            ST_ADV:  state_reg <= ST_ADV_WR;
                            ST_TICK: state_reg <= ST_IDLE;
                            default: state_reg <= ST_OUT;
                        endcase
                    end
                end
                ST_ADV_WR:
                begin
                    if (hit_found_reg || free_found_reg)
                        valid_reg[hit_found_reg ? hit_reg : free_reg] <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        if (best_found_reg)
                        begin
                            // another entry follows, so the held one is not last
                            if (count_reg != '0)
                            begin
                                out_e_reg <= hold_e_reg;
                                out_last_reg <= 1'b0;
                                out_empty_reg <= 1'b0;
                            end
                            hold_e_reg <= best_e_reg;
                            taken_reg[best_reg] <= 1'b1;
                            count_reg <= count_reg + 1'b1;
                            best_found_reg <= 1'b0;
                            scan_reg <= '0;
                            rd_pend_reg <= 1'b0;
                            if (count_reg == RW'(MAX_REPORT - 1))
                                state_reg <= ST_OUT;
                            else
                                state_reg <= ST_RPT;
                        end
                        else
                        begin
                            if (count_reg == '0)
                                out_e_reg <= '0;
                            else
                                out_e_reg <= hold_e_reg;
                            out_last_reg <= 1'b1;
                            out_empty_reg <= (count_reg == '0);
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg)
        else $error("result dropped while stalled");
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_empty_reg |-> out_last_reg)
        else $error("empty report not last");

endmodule
